// File: rtl/core/vrq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the vruntime ready queue
package vrq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_BITS     = 16;
    localparam int KEY_BITS    = 63;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 2);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_IDLE_INSERT = 2'd1,
        ST_FULL_DROP   = 2'd2,
        ST_EMPTY_IDLE  = 2'd3
    } status_t;

    typedef struct packed {
        logic                op;
        logic [ID_BITS-1:0]  task_id;
        logic [KEY_BITS-1:0] run_key;
    } in_item_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    out_task_id;
        logic [KEY_BITS-1:0]   out_key;
        status_t               status;
        logic [COUNT_BITS-1:0] task_count;
    } out_item_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  id;
    } cell_data_t;

    typedef struct packed {
        logic                insert;
        logic                take;
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  id;
    } cell_cmd_t;

endpackage

// File: rtl/core/vrq_cell.sv
`timescale 1ns / 1ps
// one queue cell: holds an entry, shifts right on insert and left on take
module vrq_cell
    import vrq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  cell_data_t left_data,
    input  logic       left_ge,
    input  cell_data_t right_data,
    output logic       ge,
    output cell_data_t data
);

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [ID_BITS-1:0]  id_reg;
    logic [ID_BITS-1:0]  id_next;

    // invalid cells count as larger than any key
    assign ge = !valid_reg || (key_reg >= cmd.key);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        id_next    = id_reg;
        if (cmd.insert)
        begin
            if (left_ge)
            begin
                valid_next = left_data.valid;
                key_next   = left_data.key;
                id_next    = left_data.id;
            end
            else if (ge)
            begin
                valid_next = 1'b1;
                key_next   = cmd.key;
                id_next    = cmd.id;
            end
        end
        else if (cmd.take)
        begin
            valid_next = right_data.valid;
            key_next   = right_data.key;
            id_next    = right_data.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign data.valid = valid_reg;
    assign data.key   = key_reg;
    assign data.id    = id_reg;

endmodule

// File: rtl/core/vruntime_ready_queue.sv
`timescale 1ns / 1ps
// vruntime ready queue: sorted task queue built as a row of shifting cells
// the result of an input transfer is in the output register in the next cycle
// throughput: one item per cycle while the input is not stalled; every cell compares the new key in parallel
// input stalls only while a finished result waits and the output is stalled
// reset empties all cells, sets the count to one and the idle id to zero
module vruntime_ready_queue
    import vrq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ID_BITS-1:0]  cfg_data
);

    logic [ID_BITS-1:0]    idle_id_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;
    out_item_t             out_item_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_cmd_t  cmd;
    cell_data_t cell_q [QUEUE_DEPTH];
    logic       ge     [QUEUE_DEPTH];
    cell_data_t empty_cell;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign is_full   = (count_reg == COUNT_BITS'(QUEUE_DEPTH + 1));
    assign is_empty  = !cell_q[0].valid;

    assign empty_cell.valid = 1'b0;
    assign empty_cell.key   = '0;
    assign empty_cell.id    = '0;

    always_comb
    begin
        cmd.insert    = 1'b0;
        cmd.take      = 1'b0;
        cmd.key       = in_item.run_key;
        cmd.id        = in_item.task_id;
        count_next    = count_reg;
        out_item_next.out_task_id = in_item.task_id;
        out_item_next.out_key     = '0;
        out_item_next.status      = ST_DONE;
        if (in_item.op == OP_INSERT)
        begin
            priority if (in_item.task_id == idle_id_reg)
            begin
                out_item_next.status = ST_IDLE_INSERT;
            end
            else if (is_full)
            begin
                out_item_next.status = ST_FULL_DROP;
            end
            else
            begin
                cmd.insert = accept;
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                out_item_next.out_task_id = idle_id_reg;
                out_item_next.status      = ST_EMPTY_IDLE;
            end
            else
            begin
                cmd.take                  = accept;
                out_item_next.out_task_id = cell_q[0].id;
                out_item_next.out_key     = cell_q[0].key;
                count_next                = count_reg - COUNT_BITS'(1);
            end
        end
        out_item_next.task_count = count_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            cell_data_t left_d;
            cell_data_t right_d;
            logic       left_g;
            if (gi == 0)
            begin : g_head
                assign left_d = empty_cell;
                assign left_g = 1'b0;
            end
            else
            begin : g_body
                assign left_d = cell_q[gi-1];
                assign left_g = ge[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_d = empty_cell;
            end
            else
            begin : g_inner
                assign right_d = cell_q[gi+1];
            end
            vrq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_data  (left_d),
                .left_ge    (left_g),
                .right_data (right_d),
                .ge         (ge[gi]),
                .data       (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_id_reg   <= '0;
            count_reg     <= COUNT_BITS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                idle_id_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (!in_stall)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: rtl/core/vrq_checker.sv
`timescale 1ns / 1ps
// port-level checker for the vruntime ready queue, bound to the top level
module vrq_checker
    import vrq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input out_item_t          out_item
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // every input transfer gives a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("input transfer without result");

    // count always covers the idle task and never passes a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.task_count >= COUNT_BITS'(1)) &&
                      (out_item.task_count <= COUNT_BITS'(QUEUE_DEPTH + 1)))
        else $error("task count out of range");

    // empty take leaves the count at one with a zero key
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_EMPTY_IDLE) |->
            (out_item.task_count == COUNT_BITS'(1)) && (out_item.out_key == '0))
        else $error("empty take with queued tasks");

    // a dropped insert only happens on a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_FULL_DROP) |->
            (out_item.task_count == COUNT_BITS'(QUEUE_DEPTH + 1)))
        else $error("insert dropped below full");

endmodule

bind vruntime_ready_queue vrq_checker u_vrq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
